@@ sv/ppbc_pkg.sv @@
// ppbc_pkg: shared types and constants for the ping-pong bit capture block.
// Used by every module under ping_pong_bit_capture_top; depends on nothing.

package ppbc_pkg;

   // Item function codes carried on req_tuser
   typedef enum logic [1:0] {
      FUNC_TICK    = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_RELEASE = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_CHANNEL_COUNT      = 1'b0,
      CSR_SAMPLES_PER_BUFFER = 1'b1
   } csr_index_type;

   localparam int FUNC_W        = 2;
   localparam int PIN_W         = 8;
   localparam int READ_INDEX_W  = 10;
   localparam int SEQ_W         = 32;
   localparam int CHAN_COUNT_W  = 4;
   localparam int SPB_W         = 11;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 11;

   localparam logic [CHAN_COUNT_W-1:0] RESET_CHANNEL_COUNT = 4'd8;
   localparam logic [SPB_W-1:0]        RESET_SPB           = 11'd1024;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 48;

   // Result queue between the control front and the output port
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_LVL_W = 3;

   // Memory operation issued by the front for one item
   typedef struct packed {
      logic write;
      logic read;
   } mem_op_type;

   // Status of one item, registered alongside the memory read
   typedef struct packed {
      logic             half_completed;
      logic             read_hit;
      logic [SEQ_W-1:0] ready_sequence;
      logic             any_ready;
   } status_type;

   // One result transaction, packed highest field first (any_ready at bit 0)
   typedef struct packed {
      logic             half_completed;
      logic [PIN_W-1:0] read_data;
      logic [SEQ_W-1:0] ready_sequence;
      logic             any_ready;
   } result_type;

endpackage

@@ sv/ping_pong_bit_capture_top.sv @@
// ping_pong_bit_capture_top: double-buffered capture of up to eight input lines.
// Instantiates ppbc_front, ppbc_store and ppbc_queue; uses ppbc_pkg.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_tvalid / req_tready | tuser: func; tdata: pins, read index
//   rsp     | out       | rsp_tvalid / rsp_tready | tdata: status, sequence, byte, done
//   csr     | in        | csr_we                  | csr_index, csr_wdata
//
// One item per cycle sustained while req_tready is high; each result passes
// through the front status register and the registered memory read, then the queue.
// The one-port sample memory takes one write (tick) or one read per cycle.
// req_tready drops only when queued results plus the item in flight reach
// the four-entry queue depth under rsp stall. Synchronous active-high reset
// clears bookkeeping and the queue; the sample memory is not cleared.

module ping_pong_bit_capture_top
   import ppbc_pkg::*;
#(
   parameter int HALF_DEPTH   = 1024,
   parameter int MAX_CHANNELS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [FUNC_W-1:0]      req_tuser,  // [1:0] func
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // [7:0] pin_levels, [17:8] read_index
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // [0] any_ready, [32:1] ready_sequence,
                                              // [40:33] read_data, [41] half_completed
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(2 * HALF_DEPTH);

   logic                   item_accept;
   mem_op_type             mem_op;
   logic [AW-1:0]          mem_addr;
   logic [PIN_W-1:0]       mem_wdata;
   logic [PIN_W-1:0]       rdata;
   logic                   stat_valid;
   status_type             stat;
   result_type             push_data;
   result_type             out_data;
   logic [QUEUE_LVL_W-1:0] level;

   assign item_accept = req_tvalid && req_tready;

   // Room for the item in flight plus everything queued
   assign req_tready = ((level + QUEUE_LVL_W'(stat_valid)) < QUEUE_LVL_W'(QUEUE_DEPTH));

   ppbc_front #(
      .HALF_DEPTH   (HALF_DEPTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .item_accept     (item_accept),
      .item_func       (req_tuser),
      .item_pins       (req_tdata[PIN_W-1:0]),
      .item_read_index (req_tdata[PIN_W +: READ_INDEX_W]),
      .mem_op          (mem_op),
      .mem_addr        (mem_addr),
      .mem_wdata       (mem_wdata),
      .stat_valid_ff   (stat_valid),
      .stat_ff         (stat)
   );

   ppbc_store #(
      .HALF_DEPTH (HALF_DEPTH)
   ) u_store (
      .clock     (clock),
      .mem_op    (mem_op),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rdata_ff  (rdata)
   );

   // Assemble the result; a read miss or non-read reports a zero byte
   always_comb begin
      push_data.any_ready      = stat.any_ready;
      push_data.ready_sequence = stat.ready_sequence;
      push_data.read_data      = stat.read_hit ? rdata : '0;
      push_data.half_completed = stat.half_completed;
   end

   ppbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (stat_valid),
      .push_data (push_data),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .level_ff  (level)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(result_type))'(0), out_data};

endmodule

@@ sv/ppbc_front.sv @@
// ppbc_front: accepts items, holds configuration and buffer bookkeeping,
// classifies each item and issues its sample memory operation. Uses ppbc_pkg.

module ppbc_front
   import ppbc_pkg::*;
#(
   parameter int HALF_DEPTH   = 1024,
   parameter int MAX_CHANNELS = 8,
   localparam int PW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1,
   localparam int AW = $clog2(2 * HALF_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    item_accept,
   input  logic [FUNC_W-1:0]       item_func,
   input  logic [PIN_W-1:0]        item_pins,
   input  logic [READ_INDEX_W-1:0] item_read_index,
   output mem_op_type              mem_op,
   output logic [AW-1:0]           mem_addr,
   output logic [PIN_W-1:0]        mem_wdata,
   output logic                    stat_valid_ff,
   output status_type              stat_ff
);

   // Compare width: holds position + 1 and the clamped buffer size
   localparam int CW = (PW + 1 > SPB_W) ? PW + 1 : SPB_W;
   localparam logic [CW-1:0] HALF_DEPTH_C = CW'(HALF_DEPTH);
   localparam logic [CHAN_COUNT_W-1:0] MAX_CHAN_C = CHAN_COUNT_W'(MAX_CHANNELS);

   logic [CHAN_COUNT_W-1:0] chan_count_ff, chan_count_in;
   logic [SPB_W-1:0]        spb_ff, spb_in;
   logic [PW-1:0]           wpos_ff, wpos_in;
   logic                    active_ff, active_in;
   logic [SEQ_W-1:0]        next_seq_ff, next_seq_in;
   logic [1:0]              ready_ff, ready_in;
   logic [SEQ_W-1:0]        half_seq_ff [2];
   logic [SEQ_W-1:0]        half_seq_in [2];
   logic                    stat_valid_in;
   status_type              stat_in;

   logic [CW-1:0]           spb_x;
   logic [CW-1:0]           eff_size;
   logic [CW-1:0]           tick_pos;
   logic                    tick_done;
   logic                    index_ok;
   logic [CHAN_COUNT_W-1:0] chan_eff;
   logic [PIN_W-1:0]        line_mask;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;

   // Configuration writes
   always_comb begin
      chan_count_in = chan_count_ff;
      spb_in        = spb_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT:      chan_count_in = csr_wdata[CHAN_COUNT_W-1:0];
            CSR_SAMPLES_PER_BUFFER: spb_in        = csr_wdata[SPB_W-1:0];
            default:                ;
         endcase
      end
   end

   // Effective half size: zero acts as one, clamp to the half depth
   assign spb_x     = CW'(spb_ff);
   assign eff_size  = (spb_x == '0) ? CW'(1) :
                      ((spb_x > HALF_DEPTH_C) ? HALF_DEPTH_C : spb_x);
   assign tick_pos  = CW'(wpos_ff) + CW'(1);
   assign tick_done = (tick_pos >= eff_size);
   assign index_ok  = (CW'(item_read_index) < eff_size);

   // Line mask from the saturated channel count
   assign chan_eff = (chan_count_ff > MAX_CHAN_C) ? MAX_CHAN_C : chan_count_ff;
   always_comb begin
      for (int i = 0; i < PIN_W; i++) begin
         line_mask[i] = (CHAN_COUNT_W'(i) < chan_eff);
      end
   end

   // Store addresses: half 1 sits above half 0
   assign wr_addr   = (active_ff ? AW'(HALF_DEPTH) : '0) + AW'(wpos_ff);
   assign rd_addr   = (ready_ff[0] ? '0 : AW'(HALF_DEPTH)) + AW'(item_read_index);
   assign mem_wdata = item_pins & line_mask;

   // Item classification and bookkeeping update
   always_comb begin
      wpos_in        = wpos_ff;
      active_in      = active_ff;
      next_seq_in    = next_seq_ff;
      ready_in       = ready_ff;
      half_seq_in[0] = half_seq_ff[0];
      half_seq_in[1] = half_seq_ff[1];
      mem_op         = '0;
      mem_addr       = wr_addr;
      stat_in        = '0;
      if (item_accept) begin
         unique case (func_type'(item_func))
            FUNC_TICK: begin
               mem_op.write = 1'b1;
               if (tick_done) begin
                  half_seq_in[active_ff] = next_seq_ff;
                  next_seq_in            = next_seq_ff + SEQ_W'(1);
                  ready_in[active_ff]    = 1'b1;
                  active_in              = ~active_ff;
                  wpos_in                = '0;
                  stat_in.half_completed = 1'b1;
               end else begin
                  wpos_in = tick_pos[PW-1:0];
               end
            end
            FUNC_READ: begin
               if ((|ready_ff) && index_ok) begin
                  mem_op.read      = 1'b1;
                  mem_addr         = rd_addr;
                  stat_in.read_hit = 1'b1;
               end
            end
            FUNC_RELEASE: begin
               if (ready_ff[0]) begin
                  ready_in[0] = 1'b0;
               end else begin
                  ready_in[1] = 1'b0;
               end
            end
            default: ;
         endcase
      end
      // Status after the item: first ready half, half 0 before half 1
      stat_in.any_ready      = |ready_in;
      stat_in.ready_sequence = ready_in[0] ? half_seq_in[0] :
                               (ready_in[1] ? half_seq_in[1] : '0);
   end

   assign stat_valid_in = item_accept;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff  <= RESET_CHANNEL_COUNT;
         spb_ff         <= RESET_SPB;
         wpos_ff        <= '0;
         active_ff      <= 1'b0;
         next_seq_ff    <= '0;
         ready_ff       <= '0;
         half_seq_ff[0] <= '0;
         half_seq_ff[1] <= '0;
         stat_valid_ff  <= 1'b0;
      end else begin
         chan_count_ff  <= chan_count_in;
         spb_ff         <= spb_in;
         wpos_ff        <= wpos_in;
         active_ff      <= active_in;
         next_seq_ff    <= next_seq_in;
         ready_ff       <= ready_in;
         half_seq_ff[0] <= half_seq_in[0];
         half_seq_ff[1] <= half_seq_in[1];
         stat_valid_ff  <= stat_valid_in;
      end
   end

   // Status payload, lines up with the registered memory read
   always_ff @(posedge clock) begin
      stat_ff <= stat_in;
   end

endmodule

@@ sv/ppbc_store.sv @@
// ppbc_store: two-half sample memory, one write or one read per cycle,
// registered read data. Uses ppbc_pkg for the operation type.

module ppbc_store
   import ppbc_pkg::*;
#(
   parameter int HALF_DEPTH = 1024,
   localparam int AW = $clog2(2 * HALF_DEPTH)
) (
   input  logic             clock,
   input  mem_op_type       mem_op,
   input  logic [AW-1:0]    mem_addr,
   input  logic [PIN_W-1:0] mem_wdata,
   output logic [PIN_W-1:0] rdata_ff
);

   logic [PIN_W-1:0] mem [2 * HALF_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_op.write) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_op.read) begin
         rdata_ff <= mem[mem_addr];
      end
   end

endmodule

@@ sv/ppbc_queue.sv @@
// ppbc_queue: short result queue feeding the rsp channel, so the front keeps
// taking items while results wait. Uses ppbc_pkg for result_type.

module ppbc_queue
   import ppbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  result_type             push_data,
   input  logic                   pop_ready,
   output logic                   out_valid,
   output result_type             out_data,
   output logic [QUEUE_LVL_W-1:0] level_ff
);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_W-1:0] level_in;
   logic                   pop;

   assign out_valid = (level_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && pop_ready;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + QUEUE_LVL_W'(push) - QUEUE_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/ppbc_checker.sv @@
// ppbc_checker: port-level checks on ping_pong_bit_capture_top, bound to it.
// Uses ppbc_pkg for port widths.

module ppbc_checker
   import ppbc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Stalled result holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // Sequence tag is zero when no half is ready
   a_seq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("sequence tag without a ready half");

   // A completed half is ready in the same result
   a_done_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41] |-> rsp_tdata[0])
      else $error("half completed but none ready");

   // A nonzero byte only comes from a ready half, never with a completed half
   a_byte_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:33] != 8'd0) |-> rsp_tdata[0] && !rsp_tdata[41])
      else $error("read byte without a ready half");

endmodule

bind ping_pong_bit_capture_top ppbc_checker u_ppbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ test/ping_pong_bit_capture_top_tb.sv @@
// ping_pong_bit_capture_top_tb: self-checking testbench for ping_pong_bit_capture_top.
// Runs a directed table and then random phases through an in-bench capture predictor.
// Depends on ppbc_pkg and ping_pong_bit_capture_top.

module ping_pong_bit_capture_top_tb;
   import ppbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 1024;
   localparam int HOLD_CYCLES = 100;
   localparam int DIR_ROWS    = 29;
   localparam int PHASES      = 7;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [FUNC_W-1:0]      req_tuser  = '0;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // [7:0] pin_levels, [17:8] read_index
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // [0] any_ready, [32:1] ready_sequence,
                                              // [40:33] read_data, [41] half_completed
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   ping_pong_bit_capture_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state: store contents, which entries were ever written, bookkeeping
   logic [7:0]  cap_store   [2][DEPTH];
   bit          cap_written [2][DEPTH];
   int unsigned wr_pos      = 0;
   bit          act_half    = 1'b0;
   logic [31:0] next_seq    = '0;
   bit          half_rdy    [2] = '{1'b0, 1'b0};
   logic [31:0] half_seq    [2] = '{32'd0, 32'd0};
   logic [3:0]  cfg_chan    = RESET_CHANNEL_COUNT;
   logic [10:0] cfg_spb     = RESET_SPB;
   int          halves_done = 0;

   result_type  pending_status [$];
   int          mismatch_count = 0;
   int          sender_burst   = 0;
   bit          hold_pending   = 1'b0;

   typedef struct {
      bit            is_cfg;
      csr_index_type reg_idx;
      logic [10:0]   reg_val;
      func_type      func;
      logic [7:0]    pins;
      logic [9:0]    ridx;
      bit            typed;
      bit            e_any;
      logic [31:0]   e_seq;
      logic [7:0]    e_data;
      bit            e_done;
   } dir_row_type;

   // Directed rows; typed expectations only where they are obvious
   dir_row_type dir_tab [DIR_ROWS] = '{
      // nothing ready after reset: read, release and no-op report all zero
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h000, 1, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_RELEASE, 8'hff, 10'h3ff, 1, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_NOP,     8'hff, 10'h3ff, 1, 0, 32'd0, 8'h00, 0},
      // zero samples per buffer behaves as one: every tick fills a half
      '{1, CSR_SAMPLES_PER_BUFFER, 11'd0, FUNC_NOP, 8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'hff, 10'h000, 1, 1, 32'd0, 8'h00, 1},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h000, 1, 1, 32'd0, 8'hff, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h001, 1, 1, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'h5a, 10'h000, 1, 1, 32'd0, 8'h00, 1},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_RELEASE, 8'h00, 10'h000, 1, 1, 32'd1, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h000, 1, 1, 32'd1, 8'h5a, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'h3c, 10'h000, 1, 1, 32'd2, 8'h00, 1},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_RELEASE, 8'h00, 10'h000, 1, 1, 32'd1, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_RELEASE, 8'h00, 10'h000, 1, 0, 32'd0, 8'h00, 0},
      // zero channels: sample bytes are all zero
      '{1, CSR_CHANNEL_COUNT, 11'd0, FUNC_NOP,     8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'hff, 10'h000, 1, 1, 32'd3, 8'h00, 1},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h000, 1, 1, 32'd3, 8'h00, 0},
      // channel count above eight saturates
      '{1, CSR_CHANNEL_COUNT, 11'd15, FUNC_NOP,    8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{1, CSR_SAMPLES_PER_BUFFER, 11'd3, FUNC_NOP, 8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'ha5, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'h96, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      // shrink the half while it is filling: next tick completes it
      '{1, CSR_SAMPLES_PER_BUFFER, 11'd1, FUNC_NOP, 8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'h0f, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      // three lines; the next tick overwrites a half that is still ready
      '{1, CSR_CHANNEL_COUNT, 11'd3, FUNC_NOP,     8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_TICK,    8'hff, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_RELEASE, 8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_READ,    8'h00, 10'h3ff, 0, 0, 32'd0, 8'h00, 0},
      '{0, CSR_CHANNEL_COUNT, 11'd0, FUNC_NOP,     8'h00, 10'h000, 0, 0, 32'd0, 8'h00, 0}
   };

   // Random phases: channel count, samples per buffer, item count (0: run until a half fills)
   logic [10:0] phase_chan  [PHASES] = '{11'd8, 11'd1, 11'd15, 11'd0, 11'd5, 11'd6, 11'd7};
   logic [10:0] phase_spb   [PHASES] = '{11'd4, 11'd1, 11'd7, 11'd2, 11'd16, 11'd2047, 11'd3};
   int          phase_items [PHASES] = '{90, 60, 90, 40, 90, 0, 60};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Effective half size after clamping
   function automatic int unsigned eff_depth();
      if (cfg_spb == 0) return 1;
      if (cfg_spb > DEPTH) return DEPTH;
      return cfg_spb;
   endfunction

   // Half 0 wins over half 1; 2 means none ready
   function automatic int first_ready();
      if (half_rdy[0]) return 0;
      if (half_rdy[1]) return 1;
      return 2;
   endfunction

   // Expected status for one accepted item; advances the predictor state
   function automatic result_type capture_predict(func_type f, logic [7:0] pins,
                                                  logic [9:0] idx);
      result_type  r;
      int          h;
      int unsigned lim;
      logic [7:0]  mask;
      r    = '0;
      lim  = eff_depth();
      mask = (cfg_chan >= 8) ? 8'hff : 8'((1 << cfg_chan) - 1);
      case (f)
         FUNC_TICK: begin
            cap_store[act_half][wr_pos]   = pins & mask;
            cap_written[act_half][wr_pos] = 1'b1;
            wr_pos++;
            if (wr_pos >= lim) begin
               half_seq[act_half] = next_seq;
               next_seq++;
               half_rdy[act_half] = 1'b1;
               act_half           = ~act_half;
               wr_pos             = 0;
               r.half_completed   = 1'b1;
               halves_done++;
            end
         end
         FUNC_READ: begin
            h = first_ready();
            if (h < 2 && idx < lim) r.read_data = cap_store[h][idx];
         end
         FUNC_RELEASE: begin
            h = first_ready();
            if (h < 2) half_rdy[h] = 1'b0;
         end
         default: ;
      endcase
      h = first_ready();
      r.any_ready      = (h < 2);
      r.ready_sequence = (h < 2) ? half_seq[h] : 32'd0;
      return r;
   endfunction

   // Steer an in-range read away from entries that were never written
   function automatic logic [9:0] safe_index(logic [9:0] idx);
      int h;
      h = first_ready();
      if (h < 2 && idx < eff_depth())
         while (idx != 0 && !cap_written[h][idx]) idx--;
      return idx;
   endfunction

   // Idle length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic func_type pick_func(int tick_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < tick_pct) return FUNC_TICK;
      r = $urandom_range(0, 9);
      if (r < 5) return FUNC_READ;
      if (r < 8) return FUNC_RELEASE;
      return FUNC_NOP;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // One request transaction; valid stays high across back-to-back items
   task automatic send_item(func_type f, logic [7:0] pins, logic [9:0] idx, bit typed,
                            result_type want);
      int gap;
      if (sender_burst > 0) begin
         sender_burst--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0) sender_burst = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {6'd0, idx, pins};
      do @(posedge clock); while (!req_tready);
      if (typed) begin
         void'(capture_predict(f, pins, idx));
         pending_status.push_back(want);
      end else begin
         pending_status.push_back(capture_predict(f, pins, idx));
      end
   endtask

   // Register write once the block has drained
   task automatic write_csr(csr_index_type i, logic [10:0] v);
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= i;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (i == CSR_CHANNEL_COUNT) cfg_chan = v[3:0];
      else cfg_spb = v;
   endtask

   // Result receiver: random stalls plus the long hold-off on request
   initial begin
      int run, stall;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end
         run = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            report_mismatch("result with none pending", rsp_tdata, '0);
         end else begin
            want = pending_status.pop_front();
            got  = result_type'(rsp_tdata[41:0]);
            if (got.any_ready != want.any_ready)
               report_mismatch("any_ready", got.any_ready, want.any_ready);
            if (got.ready_sequence != want.ready_sequence)
               report_mismatch("ready_sequence", got.ready_sequence, want.ready_sequence);
            if (got.read_data != want.read_data)
               report_mismatch("read_data", got.read_data, want.read_data);
            if (got.half_completed != want.half_completed)
               report_mismatch("half_completed", got.half_completed, want.half_completed);
            if (rsp_tdata[47:42] != '0)
               report_mismatch("tdata padding", rsp_tdata[47:42], '0);
         end
      end
   end

   // Stimulus: reset, directed table, random phases, drain
   initial begin
      result_type  want;
      func_type    f;
      logic [7:0]  pins;
      logic [9:0]  idx;
      int          n, done_before, tick_pct;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_cfg) begin
            write_csr(dir_tab[i].reg_idx, dir_tab[i].reg_val);
         end else begin
            want                = '0;
            want.any_ready      = dir_tab[i].e_any;
            want.ready_sequence = dir_tab[i].e_seq;
            want.read_data      = dir_tab[i].e_data;
            want.half_completed = dir_tab[i].e_done;
            send_item(dir_tab[i].func, dir_tab[i].pins, dir_tab[i].ridx, dir_tab[i].typed,
                      want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_csr(CSR_CHANNEL_COUNT, phase_chan[p]);
         write_csr(CSR_SAMPLES_PER_BUFFER, phase_spb[p]);
         if (p == 2 || p == 5) hold_pending = 1'b1;
         tick_pct    = (phase_items[p] == 0) ? 85 : 50;
         done_before = halves_done;
         n           = 0;
         while ((phase_items[p] != 0) ? (n < phase_items[p])
                                      : (halves_done == done_before && n < 3000)) begin
            f    = pick_func(tick_pct);
            pins = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0) idx = 10'($urandom_range(0, eff_depth() - 1));
            else idx = 10'($urandom_range(0, DEPTH - 1));
            if (f == FUNC_READ) idx = safe_index(idx);
            send_item(f, pins, idx, 1'b0, '0);
            n++;
         end
      end

      // Drain, then allow for the pipeline latency
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
